// ===== rtl/tsd_pkg.sv =====
// Shared types, constants and the CRC-8 helper for the thermometer scratchpad decoder.
package tsd_pkg;

    localparam int unsigned SENSOR_COUNT = 4;
    localparam int unsigned SENSOR_W     = 2;
    localparam int unsigned FOUND_W      = 3;
    localparam int unsigned TEMP_W       = 16;
    localparam int unsigned FRAME_BYTES  = 9;
    localparam int unsigned POS_W        = 4;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QUEUE_PTR_W  = 1;
    localparam int unsigned QUEUE_CNT_W  = 2;

    localparam logic [POS_W-1:0] POS_TEMP_LOW  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TEMP_HIGH = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CONFIG    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SENSORS_FOUND = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_3  = 3'd4;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_ZERO  = 2'd2;
    localparam status_t ST_CRC   = 2'd3;

    // Resolution field codes (byte 4 bits 6..5)
    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    typedef struct packed {
        logic [7:0]          scratch_byte;
        logic [SENSOR_W-1:0] sensor;
        logic                all_sensors;
    } in_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [TEMP_W-1:0] temperature;
    } out_item_t;

    // Classified frame handed from the front to the back
    typedef struct packed {
        status_t             status;
        logic [TEMP_W-1:0]   raw;
        logic [SENSOR_W-1:0] corr_sel;
    } frame_t;

    typedef logic [SENSOR_COUNT-1:0][TEMP_W-1:0] corr_array_t;

    // Dallas CRC-8, reflected, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/tsd_front.sv =====
// Front end: takes scratchpad bytes, runs the CRC and classifies each finished frame.
module tsd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  tsd_pkg::in_item_t             scratch,
    input  logic [tsd_pkg::FOUND_W-1:0]   sensors_found,
    output logic                          frame_push,
    output tsd_pkg::frame_t               frame,
    input  logic                          queue_full
);
    import tsd_pkg::*;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    logic                nz_reg, nz_next;
    logic [7:0]          tlo_reg, tlo_next;
    logic [7:0]          thi_reg, thi_next;
    logic [1:0]          res_reg, res_next;
    logic [SENSOR_W-1:0] sensor_reg, sensor_next;
    logic                all_reg, all_next;

    logic                accept;
    logic                first;
    logic                last;
    logic [7:0]          crc_base;
    logic [SENSOR_W-1:0] sensor_eff;
    logic                all_eff;
    logic                range_bad;
    logic [TEMP_W-1:0]   raw_full;
    logic [TEMP_W-1:0]   raw_masked;

    // Stall only on the closing byte when the queue cannot take the frame
    assign first  = (pos_reg == POS_TEMP_LOW);
    assign last   = (pos_reg == POS_LAST);
    assign full   = last && queue_full;
    assign accept = push && !full;

    assign crc_base   = first ? 8'h00 : crc_reg;
    assign sensor_eff = first ? scratch.sensor : sensor_reg;
    assign all_eff    = first ? scratch.all_sensors : all_reg;

    // Byte-by-byte accumulation
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        nz_next     = nz_reg;
        tlo_next    = tlo_reg;
        thi_next    = thi_reg;
        res_next    = res_reg;
        sensor_next = sensor_reg;
        all_next    = all_reg;
        if (accept)
        begin
            crc_next    = crc8_update(crc_base, scratch.scratch_byte);
            nz_next     = (first ? 1'b0 : nz_reg) | (scratch.scratch_byte != 8'h00);
            sensor_next = sensor_eff;
            all_next    = all_eff;
            if (pos_reg == POS_TEMP_LOW)
                tlo_next = scratch.scratch_byte;
            if (pos_reg == POS_TEMP_HIGH)
                thi_next = scratch.scratch_byte;
            if (pos_reg == POS_CONFIG)
                res_next = scratch.scratch_byte[6:5];
            pos_next = last ? POS_TEMP_LOW : pos_reg + POS_W'(1);
        end
    end

    // Clear low bits according to resolution
    assign raw_full = {thi_reg, tlo_reg};
    always_comb
    begin
        unique case (res_reg)
            RES_9BIT:  raw_masked = raw_full & ~TEMP_W'(7);
            RES_10BIT: raw_masked = raw_full & ~TEMP_W'(3);
            RES_11BIT: raw_masked = raw_full & ~TEMP_W'(1);
            RES_12BIT: raw_masked = raw_full;
            default:   raw_masked = raw_full;
        endcase
    end

    // Classify the frame on its closing byte
    assign range_bad = !all_eff &&
                       (({1'b0, sensor_eff} >= sensors_found) ||
                        (32'(sensor_eff) >= SENSOR_COUNT));

    always_comb
    begin
        if (range_bad)
            frame.status = ST_RANGE;
        else if (!nz_next)
            frame.status = ST_ZERO;
        else if (crc_next != 8'h00)
            frame.status = ST_CRC;
        else
            frame.status = ST_OK;
        frame.raw      = raw_masked;
        frame.corr_sel = all_eff ? '0 : sensor_eff;
    end

    assign frame_push = accept && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            crc_reg    <= '0;
            nz_reg     <= 1'b0;
            tlo_reg    <= '0;
            thi_reg    <= '0;
            res_reg    <= '0;
            sensor_reg <= '0;
            all_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            nz_reg     <= nz_next;
            tlo_reg    <= tlo_next;
            thi_reg    <= thi_next;
            res_reg    <= res_next;
            sensor_reg <= sensor_next;
            all_reg    <= all_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < FRAME_BYTES)
        else $error("front byte position out of range");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_push |=> pos_reg == POS_TEMP_LOW)
        else $error("byte position did not restart after closing byte");
`endif

endmodule

// ===== rtl/tsd_queue.sv =====
// Short queue of classified frames between the front and the back.
module tsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tsd_pkg::frame_t wr_data,
    output logic            q_full,
    input  logic            rd_en,
    output tsd_pkg::frame_t rd_data,
    output logic            q_empty
);
    import tsd_pkg::*;

    frame_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   do_wr;
    logic                   do_rd;

    assign q_full  = (32'(cnt_reg) == QUEUE_DEPTH);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("frame pushed into a full queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/tsd_back.sv =====
// Back end: applies the sensor correction and holds the result for the consumer.
module tsd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  tsd_pkg::frame_t       q_data,
    output logic                  q_pop,
    input  tsd_pkg::corr_array_t  corrections,
    output logic                  empty,
    input  logic                  pop,
    output tsd_pkg::out_item_t    reading
);
    import tsd_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t out_reg, out_next;
    logic      load;

    // Take a frame when the output slot is free or being drained
    assign load  = !q_empty && (!valid_reg || pop);
    assign q_pop = load;

    always_comb
    begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (pop && valid_reg)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next         = 1'b1;
            out_next.status    = q_data.status;
            out_next.temperature = (q_data.status == ST_OK) ?
                TEMP_W'(q_data.raw + corrections[q_data.corr_sel]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty   = !valid_reg;
    assign reading = out_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (reading.status != ST_OK) |-> reading.temperature == '0)
        else $error("error result carries a nonzero temperature");
`endif

endmodule

// ===== rtl/thermometer_scratchpad_decoder.sv =====
// Top level of the thermometer scratchpad decoder with its configuration registers.
//
// Feed the nine scratchpad bytes of a frame one per transfer, byte 0 first;
// sensor and all_sensors are sampled with byte 0. Bytes are taken at one per
// clock unless full. Each ninth byte produces one result. The classified
// frame enters a two-entry queue at the edge that takes the ninth byte. When
// the output register is free, the result is on the result ports after the
// next clock edge. full rises only on a ninth byte while the queue already
// holds two frames that the consumer has not drained. Status is 0 ok,
// 1 sensor out of range, 2 all bytes zero, 3 CRC mismatch; error results
// carry temperature 0. Configuration (index 0 sensors_found, 1..4
// correction_0..3) is to be written only while idle.
module thermometer_scratchpad_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  tsd_pkg::in_item_t                 scratch,
    output logic                              empty,
    input  logic                              pop,
    output tsd_pkg::out_item_t                reading,
    input  logic                              cfg_write,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tsd_pkg::*;

    logic [FOUND_W-1:0] found_reg, found_next;
    corr_array_t        corr_reg, corr_next;

    logic   frame_push;
    frame_t frame;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    frame_t q_data;

    // Register writes
    always_comb
    begin
        found_next = found_reg;
        corr_next  = corr_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SENSORS_FOUND: found_next  = cfg_data[FOUND_W-1:0];
                REG_CORRECTION_0:  corr_next[0] = cfg_data[TEMP_W-1:0];
                REG_CORRECTION_1:  corr_next[1] = cfg_data[TEMP_W-1:0];
                REG_CORRECTION_2:  corr_next[2] = cfg_data[TEMP_W-1:0];
                REG_CORRECTION_3:  corr_next[3] = cfg_data[TEMP_W-1:0];
                default:           found_next  = found_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
            corr_reg  <= '0;
        end
        else
        begin
            found_reg <= found_next;
            corr_reg  <= corr_next;
        end
    end

    tsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .scratch       (scratch),
        .sensors_found (found_reg),
        .frame_push    (frame_push),
        .frame         (frame),
        .queue_full    (q_full)
    );

    tsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_push),
        .wr_data (frame),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    tsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .corrections (corr_reg),
        .empty       (empty),
        .pop         (pop),
        .reading     (reading)
    );

endmodule

// ===== verif/thermometer_scratchpad_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the thermometer scratchpad decoder: framed byte traffic and scoreboard.
module thermometer_scratchpad_decoder_tb;
    import tsd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int STALL_CYCLES     = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_CORRECTION_3 + 3'd1;

    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_ZERO, FRAME_NOISE} frame_kind_t;
    typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic                   full;
    in_item_t               scratch   = '0;
    logic                   empty;
    logic                   pop       = 1'b0;
    out_item_t              reading;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Decoder state mirrored by the testbench
    logic [POS_W-1:0]   frame_pos     = '0;
    logic [7:0]         crc_acc       = '0;
    logic               saw_nonzero   = 1'b0;
    logic [7:0]         temp_lo       = '0;
    logic [7:0]         temp_hi       = '0;
    logic [1:0]         res_field     = '0;
    logic [SENSOR_W-1:0] frame_sensor = '0;
    logic               frame_all     = 1'b0;
    logic [FOUND_W-1:0] found_count   = '0;
    logic [TEMP_W-1:0]  sensor_offset [SENSOR_COUNT] = '{default: '0};

    out_item_t pending_readings[$];
    int        errors         = 0;
    int        tx_idle_pct    = 34;
    int        rx_idle_pct    = 34;
    int        rx_hold_cycles = 0;
    int        quiet_cycles   = 0;

    thermometer_scratchpad_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .scratch   (scratch),
        .empty     (empty),
        .pop       (pop),
        .reading   (reading),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bitwise Dallas CRC-8: one data bit per step, LSB first
    function automatic logic [7:0] dallas_crc(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       mix;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            mix = acc[0] ^ data[i];
            acc = acc >> 1;
            if (mix)
                acc = acc ^ 8'h8C;
        end
        return acc;
    endfunction

    // Replace byte 8 with the CRC of bytes 0..7
    function automatic frame_bytes_t seal_crc(input frame_bytes_t fb);
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            crc = dallas_crc(crc, fb[i]);
        fb[FRAME_BYTES-1] = crc;
        return fb;
    endfunction

    function automatic frame_bytes_t make_frame(input frame_kind_t kind);
        frame_bytes_t fb;
        for (int i = 0; i < FRAME_BYTES; i++)
            fb[i] = 8'($urandom_range(255));
        // Pull the raw temperature to an extreme now and then
        case ($urandom_range(7))
            0: {fb[1], fb[0]} = 16'h7FFF;
            1: {fb[1], fb[0]} = 16'h8000;
            2: {fb[1], fb[0]} = 16'hFFFF;
            3: {fb[1], fb[0]} = 16'h0000;
            default: ;
        endcase
        case (kind)
            FRAME_GOOD:    fb = seal_crc(fb);
            FRAME_BAD_CRC:
            begin
                fb = seal_crc(fb);
                fb[FRAME_BYTES-1] = fb[FRAME_BYTES-1] ^ 8'($urandom_range(1, 255));
            end
            FRAME_ZERO:    fb = '0;
            default: ;
        endcase
        return fb;
    endfunction

    // Advance the mirrored decoder by one byte; queue a reading on the ninth
    task automatic decode_scratch_byte(input in_item_t it);
        out_item_t         r;
        logic [TEMP_W-1:0] raw;
        logic [TEMP_W-1:0] offset;
        if (frame_pos == POS_TEMP_LOW)
        begin
            frame_sensor = it.sensor;
            frame_all    = it.all_sensors;
            crc_acc      = '0;
            saw_nonzero  = 1'b0;
        end
        crc_acc = dallas_crc(crc_acc, it.scratch_byte);
        if (it.scratch_byte != 8'h00)
            saw_nonzero = 1'b1;
        case (frame_pos)
            POS_TEMP_LOW:  temp_lo = it.scratch_byte;
            POS_TEMP_HIGH: temp_hi = it.scratch_byte;
            POS_CONFIG:    res_field = it.scratch_byte[6:5];
            default: ;
        endcase
        if (frame_pos != POS_LAST)
            frame_pos = frame_pos + 1'b1;
        else
        begin
            frame_pos = '0;
            r = '0;
            if (!frame_all && (frame_sensor >= found_count || frame_sensor >= SENSOR_COUNT))
                r.status = ST_RANGE;
            else if (!saw_nonzero)
                r.status = ST_ZERO;
            else if (crc_acc != 8'h00)
                r.status = ST_CRC;
            else
                r.status = ST_OK;
            if (r.status == ST_OK)
            begin
                raw = {temp_hi, temp_lo};
                case (res_field)
                    RES_9BIT:  raw = raw & 16'hFFF8;
                    RES_10BIT: raw = raw & 16'hFFFC;
                    RES_11BIT: raw = raw & 16'hFFFE;
                    default: ;
                endcase
                offset = frame_all ? sensor_offset[0] : sensor_offset[frame_sensor];
                r.temperature = raw + offset;
            end
            pending_readings.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Offer one byte, idling at random first; return on its transfer
    task automatic send_byte(input in_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        scratch <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_scratch_byte(it);
    endtask

    // Sensor and flag only count on byte 0; randomize them elsewhere
    task automatic send_frame(input frame_bytes_t fb, input logic [SENSOR_W-1:0] sensor,
                              input logic all_flag);
        in_item_t it;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            it.scratch_byte = fb[i];
            it.sensor       = (i == 0) ? sensor : SENSOR_W'($urandom_range(3));
            it.all_sensors  = (i == 0) ? all_flag : 1'($urandom_range(1));
            send_byte(it);
        end
    endtask

    // Stop offering and hold until every reading has come back
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SENSORS_FOUND: found_count = data[FOUND_W-1:0];
            REG_CORRECTION_0:  sensor_offset[0] = data;
            REG_CORRECTION_1:  sensor_offset[1] = data;
            REG_CORRECTION_2:  sensor_offset[2] = data;
            REG_CORRECTION_3:  sensor_offset[3] = data;
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Upper data bits are don't-care for the count register
    task automatic write_found(input logic [FOUND_W-1:0] count);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[FOUND_W-1:0] = count;
        write_reg(REG_SENSORS_FOUND, data);
    endtask

    task automatic write_offsets(input logic [TEMP_W-1:0] c0, input logic [TEMP_W-1:0] c1,
                                 input logic [TEMP_W-1:0] c2, input logic [TEMP_W-1:0] c3);
        write_reg(REG_CORRECTION_0, c0);
        write_reg(REG_CORRECTION_1, c1);
        write_reg(REG_CORRECTION_2, c2);
        write_reg(REG_CORRECTION_3, c3);
    endtask

    // Reset defaults: no sensors found, so only all-sensor reads pass
    task automatic test_reset_defaults();
        send_frame(make_frame(FRAME_GOOD), 2'd0, 1'b0);
        send_frame(make_frame(FRAME_GOOD), 2'd3, 1'b1);
        send_frame(make_frame(FRAME_ZERO), 2'd1, 1'b0);
        wait_idle();
    endtask

    // Offset extremes, every resolution, zero and CRC error frames
    task automatic test_directed_cases();
        frame_bytes_t fb;
        write_found(3'(SENSOR_COUNT));
        write_offsets(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
        fb = make_frame(FRAME_GOOD);
        {fb[1], fb[0]} = 16'h7FFF;
        fb[4][6:5] = RES_12BIT;
        send_frame(seal_crc(fb), 2'd0, 1'b0);
        fb = make_frame(FRAME_GOOD);
        {fb[1], fb[0]} = 16'h8007;
        fb[4][6:5] = RES_9BIT;
        send_frame(seal_crc(fb), 2'd1, 1'b0);
        fb = make_frame(FRAME_GOOD);
        {fb[1], fb[0]} = 16'hFFFF;
        fb[4][6:5] = RES_10BIT;
        send_frame(seal_crc(fb), 2'd3, 1'b1);
        fb = make_frame(FRAME_GOOD);
        {fb[1], fb[0]} = 16'h0003;
        fb[4][6:5] = RES_11BIT;
        send_frame(seal_crc(fb), 2'd2, 1'b0);
        send_frame(make_frame(FRAME_ZERO), 2'd2, 1'b0);
        send_frame(make_frame(FRAME_BAD_CRC), 2'd3, 1'b0);
        wait_idle();
    endtask

    // Writes past the last register must leave every register alone
    task automatic test_ignored_indexes();
        for (int i = REG_UNUSED_FIRST; i < (1 << CFG_INDEX_W); i++)
            write_reg(i[CFG_INDEX_W-1:0], CFG_DATA_W'($urandom));
        for (int s = 0; s < SENSOR_COUNT; s++)
            send_frame(make_frame(FRAME_GOOD), s[SENSOR_W-1:0], 1'b0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        frame_kind_t kind;
        int          pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: write_found('0);
                1:
                begin
                    write_found('1);
                    write_offsets(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
                end
                2: write_found(3'(SENSOR_COUNT));
                default:
                begin
                    write_found(FOUND_W'($urandom_range(7)));
                    write_offsets(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                end
            endcase
            // One phase runs back to back on both sides
            tx_idle_pct = (phase == 3) ? 0 : 34;
            rx_idle_pct = (phase == 3) ? 0 : 34;
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    kind = FRAME_GOOD;
                else if (pick < 87)
                    kind = FRAME_BAD_CRC;
                else if (pick < 93)
                    kind = FRAME_ZERO;
                else
                    kind = FRAME_NOISE;
                send_frame(make_frame(kind), SENSOR_W'($urandom_range(3)),
                           ($urandom_range(3) == 0));
            end
            wait_idle();
        end
        tx_idle_pct = 34;
        rx_idle_pct = 34;
    endtask

    // Hold off the consumer while frames keep coming so the input stalls
    task automatic test_backpressure();
        write_found(3'(SENSOR_COUNT));
        tx_idle_pct = 0;
        rx_hold_cycles <= STALL_CYCLES;
        for (int f = 0; f < 6; f++)
            send_frame(make_frame(FRAME_GOOD), SENSOR_W'($urandom_range(3)),
                       ($urandom_range(3) == 0));
        wait_idle();
        tx_idle_pct = 34;
    endtask

    // Consumer: random pops, or a counted hold when one is requested
    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            pop <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each transfer on the result side with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("unexpected reading", 32'(reading), '0);
            else
            begin
                want = pending_readings.pop_front();
                if (reading.status !== want.status)
                    report_mismatch("status", 32'(reading.status), 32'(want.status));
                if (reading.temperature !== want.temperature)
                    report_mismatch("temperature", 32'(reading.temperature),
                                    32'(want.temperature));
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d readings outstanding",
                     $realtime, pending_readings.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_ignored_indexes();
        test_random_frames();
        test_backpressure();
        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
